// File: rtl/sxd_pkg.sv
package sxd_pkg;

	localparam logic [31:0] WHITE   = 32'hFFFF_FFFF;
	localparam logic [15:0] NUM_MAX = 16'hFFFF;
	localparam int SUM_W = 18;
	localparam int DIV_W = 29;
	localparam int DEN_W = 20;

	localparam logic [7:0] SIX_LO    = 8'h3F;
	localparam logic [7:0] SIX_HI    = 8'h7E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic       REQ_END   = 1'b1;
	localparam logic       KIND_RUN  = 1'b0;
	localparam logic       KIND_SIZE = 1'b1;

	localparam logic [15:0] PU_HLS = 16'd1;
	localparam logic [15:0] PU_RGB = 16'd2;

	localparam logic [DEN_W-1:0] DEN_PCT = DEN_W'(100);
	localparam logic [DEN_W-1:0] DEN_HLS = DEN_W'(600000);
	localparam logic [DIV_W-1:0] HLS_RND = DIV_W'(300000);

	// x / 100 = (x * RCP_PCT) >> 31 for x below 2^24
	localparam logic [24:0] RCP_PCT = 25'd21474837;
	// x / 600000 = ((x >> 6) * RCP_HLS) >> 37 for x below 2^29
	localparam logic [23:0] RCP_HLS = 24'd14660156;

	typedef enum logic [3:0] {
		M_GROUND, M_REPEAT, M_PC, M_PU, M_PX, M_PY, M_PZ
	} mode_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SEL_RD, S_CALC_GO, S_CALC, S_GROUND, S_PAINT, S_SIZE
	} state_t;

	typedef enum logic [2:0] {
		C_IDLE, C_PQ, C_HUE, C_DIVIN, C_DIV, C_DONE
	} calc_state_t;

	typedef struct packed {
		logic        start;
		logic [15:0] pu;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
	} calc_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] color;
	} calc_rsp_t;

	function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
		logic [19:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
		return (v > 20'(NUM_MAX)) ? NUM_MAX : v[15:0];
	endfunction

endpackage

// File: rtl/sixel_stream_decoder_top.sv
// Sixel body decoder. Bytes and end-of-image markers enter on the input
// channel; each sixel character with bits set inside the image bounds
// yields one column-run result, and an end marker yields the used image
// size. A byte that only feeds a number passes IDLE and DECODE, a control
// byte also GROUND, a painted sixel GROUND and PAINT, or only PAINT when it
// ends a repeat; a colour select adds the palette read, and a colour
// definition the colour calculation, using reciprocal multiplies.
// The palette is one memory of COLOR_REGS words; after reset and after every
// end-of-image result it is swept back to white, and no input is taken
// during the sweep. The output register lets the next byte enter while a
// result waits to be taken.
module sixel_stream_decoder_top #(
	parameter int COLOR_REGS = 1024,
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [11:0] col_x,
	output logic [11:0] band_y,
	output logic [5:0]  pixel_mask,
	output logic [12:0] run_length,
	output logic [31:0] pixel_color,
	output logic [12:0] image_width,
	output logic [12:0] image_height
);

	localparam int AW = (COLOR_REGS > 1) ? $clog2(COLOR_REGS) : 1;
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = sxd_pkg::SUM_W;

	sxd_pkg::state_t st_q, st_d;
	sxd_pkg::mode_t  mode_q;

	logic        req_q;
	logic [7:0]  byte_q;
	logic [15:0] acc_q, pc_q, pu_q, px_q, py_q, pz_q, cnt_q, sel_idx_q;
	logic [31:0] sel_color_q;
	logic [XW-1:0] col_q, used_w_q;
	logic [YW-1:0] band_q, used_h_q;
	logic [AW-1:0] clr_q;

	logic        out_valid_q, kind_q;
	logic [11:0] col_x_q, band_y_q;
	logic [5:0]  mask_q;
	logic [12:0] run_q, img_w_q, img_h_q;
	logic [31:0] color_q;

	logic        is_digit, is_semi, is_six, acc_lt, pc_lt, slot_free, last_clr;
	logic        mem_we, paint_go, size_go;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata, mem_rdata;
	sxd_pkg::calc_req_t calc_req;
	sxd_pkg::calc_rsp_t calc_rsp;

	logic [5:0]  mask_c, cmask;
	logic [2:0]  top_c;
	logic [SW-1:0] col_e, band_e, need_x, need_y, nx_sat, ny_sat, avail, run_c;
	logic        emit;
	logic [XW-1:0] w_fin;
	logic [YW-1:0] h_fin;

	sxd_color_mem #(.DEPTH(COLOR_REGS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (acc_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	sxd_color_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.rsp    (calc_rsp)
	);

	always_comb begin
		is_digit  = byte_q >= sxd_pkg::CH_ZERO && byte_q <= sxd_pkg::CH_NINE;
		is_semi   = byte_q == sxd_pkg::CH_SEMI;
		is_six    = byte_q >= sxd_pkg::SIX_LO && byte_q <= sxd_pkg::SIX_HI;
		acc_lt    = {1'b0, acc_q} < 17'(COLOR_REGS);
		pc_lt     = {1'b0, pc_q} < 17'(COLOR_REGS);
		slot_free = !out_valid_q || out_ready;
		last_clr  = clr_q == AW'(COLOR_REGS - 1);
	end

	// column run geometry
	always_comb begin
		mask_c = 6'(byte_q - sxd_pkg::SIX_LO);
		top_c  = 3'd0;
		for (int k = 0; k < 6; k++) begin
			if (mask_c[k]) top_c = 3'(k);
		end
		col_e  = SW'(col_q);
		band_e = SW'(band_q);
		for (int k = 0; k < 6; k++) begin
			cmask[k] = mask_c[k] && (band_e + SW'(k) < SW'(MAX_HEIGHT));
		end
		need_x = col_e + SW'(cnt_q);
		need_y = band_e + SW'(top_c) + SW'(1);
		nx_sat = (need_x > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : need_x;
		ny_sat = (need_y > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : need_y;
		avail  = SW'(MAX_WIDTH) - col_e;
		run_c  = (SW'(cnt_q) < avail) ? SW'(cnt_q) : avail;
		emit   = col_e < SW'(MAX_WIDTH) && cmask != 6'd0;
		w_fin  = (used_w_q == '0 || used_h_q == '0) ? '0 : used_w_q;
		h_fin  = (used_w_q == '0 || used_h_q == '0) ? '0 : used_h_q;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			sxd_pkg::S_CLEAR: if (last_clr) st_d = sxd_pkg::S_IDLE;
			sxd_pkg::S_IDLE:  if (in_valid) st_d = sxd_pkg::S_DECODE;
			sxd_pkg::S_DECODE: begin
				if (req_q == sxd_pkg::REQ_END) begin
					st_d = sxd_pkg::S_SIZE;
				end else begin
					case (mode_q)
						sxd_pkg::M_GROUND: st_d = sxd_pkg::S_GROUND;
						sxd_pkg::M_REPEAT: begin
							if (is_digit) st_d = sxd_pkg::S_IDLE;
							else if (is_six) st_d = sxd_pkg::S_PAINT;
							else st_d = sxd_pkg::S_IDLE;
						end
						sxd_pkg::M_PC: begin
							if (is_digit || is_semi) st_d = sxd_pkg::S_IDLE;
							else if (acc_lt) st_d = sxd_pkg::S_SEL_RD;
							else st_d = sxd_pkg::S_GROUND;
						end
						sxd_pkg::M_PZ: begin
							if (is_digit) st_d = sxd_pkg::S_IDLE;
							else st_d = sxd_pkg::S_CALC_GO;
						end
						default: begin
							if (is_digit || is_semi) st_d = sxd_pkg::S_IDLE;
							else st_d = sxd_pkg::S_CALC_GO;
						end
					endcase
				end
			end
			sxd_pkg::S_SEL_RD:  st_d = sxd_pkg::S_GROUND;
			sxd_pkg::S_CALC_GO: st_d = sxd_pkg::S_CALC;
			sxd_pkg::S_CALC:    if (calc_rsp.done) st_d = sxd_pkg::S_GROUND;
			sxd_pkg::S_GROUND:  st_d = is_six ? sxd_pkg::S_PAINT : sxd_pkg::S_IDLE;
			sxd_pkg::S_PAINT:   if (slot_free) st_d = sxd_pkg::S_IDLE;
			sxd_pkg::S_SIZE:    if (slot_free) st_d = sxd_pkg::S_CLEAR;
			default:            st_d = sxd_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		in_ready       = st_q == sxd_pkg::S_IDLE;
		paint_go       = st_q == sxd_pkg::S_PAINT && slot_free;
		size_go        = st_q == sxd_pkg::S_SIZE && slot_free;
		calc_req.start = st_q == sxd_pkg::S_CALC_GO;
		calc_req.pu    = pu_q;
		calc_req.px    = px_q;
		calc_req.py    = py_q;
		calc_req.pz    = pz_q;
		if (st_q == sxd_pkg::S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = sxd_pkg::WHITE;
		end else begin
			mem_we    = st_q == sxd_pkg::S_CALC && calc_rsp.done && pc_lt;
			mem_waddr = pc_q[AW-1:0];
			mem_wdata = calc_rsp.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= sxd_pkg::S_CLEAR;
			mode_q      <= sxd_pkg::M_GROUND;
			clr_q       <= '0;
			acc_q       <= '0;
			sel_idx_q   <= '0;
			sel_color_q <= sxd_pkg::WHITE;
			col_q       <= '0;
			band_q      <= '0;
			used_w_q    <= '0;
			used_h_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == sxd_pkg::S_CLEAR) clr_q <= last_clr ? '0 : clr_q + AW'(1);
			out_valid_q <= paint_go && emit || size_go || (out_valid_q && !out_ready);
			case (st_q)
				sxd_pkg::S_DECODE: begin
					if (req_q != sxd_pkg::REQ_END && mode_q != sxd_pkg::M_GROUND) begin
						if (is_digit) begin
							acc_q <= sxd_pkg::add_digit(acc_q, 4'(byte_q - sxd_pkg::CH_ZERO));
						end else if (is_semi && mode_q != sxd_pkg::M_REPEAT
							&& mode_q != sxd_pkg::M_PZ) begin
							acc_q  <= '0;
							mode_q <= sxd_pkg::mode_t'(4'(mode_q) + 4'd1);
						end else begin
							acc_q  <= '0;
							mode_q <= sxd_pkg::M_GROUND;
							if (mode_q == sxd_pkg::M_PC) begin
								sel_idx_q <= acc_q;
								if (!acc_lt) sel_color_q <= sxd_pkg::WHITE;
							end
						end
					end
				end
				sxd_pkg::S_SEL_RD: sel_color_q <= mem_rdata;
				sxd_pkg::S_CALC: begin
					if (calc_rsp.done && pc_lt && pc_q == sel_idx_q) begin
						sel_color_q <= calc_rsp.color;
					end
				end
				sxd_pkg::S_GROUND: begin
					if (byte_q == sxd_pkg::CH_DOLLAR) begin
						col_q <= '0;
					end else if (byte_q == sxd_pkg::CH_DASH) begin
						col_q  <= '0;
						band_q <= (SW'(band_q) + SW'(6) > SW'(MAX_HEIGHT)) ?
							YW'(MAX_HEIGHT) : YW'(SW'(band_q) + SW'(6));
					end else if (byte_q == sxd_pkg::CH_BANG) begin
						mode_q <= sxd_pkg::M_REPEAT;
						acc_q  <= '0;
					end else if (byte_q == sxd_pkg::CH_HASH) begin
						mode_q <= sxd_pkg::M_PC;
						acc_q  <= '0;
					end
				end
				sxd_pkg::S_PAINT: begin
					if (slot_free) begin
						col_q <= nx_sat[XW-1:0];
						if (mask_c != 6'd0) begin
							if (nx_sat > SW'(used_w_q)) used_w_q <= nx_sat[XW-1:0];
							if (ny_sat > SW'(used_h_q)) used_h_q <= ny_sat[YW-1:0];
						end
					end
				end
				sxd_pkg::S_SIZE: begin
					if (slot_free) begin
						mode_q      <= sxd_pkg::M_GROUND;
						acc_q       <= '0;
						sel_idx_q   <= '0;
						sel_color_q <= sxd_pkg::WHITE;
						col_q       <= '0;
						band_q      <= '0;
						used_w_q    <= '0;
						used_h_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// parameter registers and item latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= req_type;
			byte_q <= byte_in;
		end
		if (st_q == sxd_pkg::S_SIZE) begin
			pc_q <= '0;
			pu_q <= '0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
		end
		if (st_q == sxd_pkg::S_DECODE && req_q != sxd_pkg::REQ_END && !is_digit) begin
			case (mode_q)
				sxd_pkg::M_REPEAT: cnt_q <= (acc_q == '0) ? 16'd1 : acc_q;
				sxd_pkg::M_PC: begin
					if (is_semi) begin
						pc_q <= acc_q;
						pu_q <= '0;
						px_q <= '0;
						py_q <= '0;
					end
				end
				sxd_pkg::M_PU: begin
					pu_q <= acc_q;
					if (!is_semi) begin
						px_q <= '0;
						py_q <= '0;
						pz_q <= '0;
					end
				end
				sxd_pkg::M_PX: begin
					px_q <= acc_q;
					if (!is_semi) begin
						py_q <= '0;
						pz_q <= '0;
					end
				end
				sxd_pkg::M_PY: begin
					py_q <= acc_q;
					if (!is_semi) pz_q <= '0;
				end
				sxd_pkg::M_PZ: pz_q <= acc_q;
				default: ;
			endcase
		end
		if (st_q == sxd_pkg::S_GROUND) cnt_q <= 16'd1;
		if (paint_go && emit) begin
			kind_q  <= sxd_pkg::KIND_RUN;
			col_x_q <= col_e[11:0];
			band_y_q <= band_e[11:0];
			mask_q  <= cmask;
			run_q   <= run_c[12:0];
			color_q <= sel_color_q;
			img_w_q <= '0;
			img_h_q <= '0;
		end else if (size_go) begin
			kind_q  <= sxd_pkg::KIND_SIZE;
			col_x_q <= '0;
			band_y_q <= '0;
			mask_q  <= '0;
			run_q   <= '0;
			color_q <= '0;
			img_w_q <= 13'(SW'(w_fin));
			img_h_q <= 13'(SW'(h_fin));
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign col_x        = col_x_q;
	assign band_y       = band_y_q;
	assign pixel_mask   = mask_q;
	assign run_length   = run_q;
	assign pixel_color  = color_q;
	assign image_width  = img_w_q;
	assign image_height = img_h_q;

endmodule

// File: rtl/sxd_color_mem.sv
module sxd_color_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sxd_chan_div.sv
module sxd_chan_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sxd_pkg::DIV_W-1:0] dividend,
	input  logic [sxd_pkg::DEN_W-1:0] divisor,
	output logic                      done,
	output logic [7:0]                quotient
);

	logic [sxd_pkg::DIV_W-1:0] num_q;
	logic                      hls_q;
	logic [7:0]                quo_q;
	logic                      busy_q;
	logic                      done_q;
	logic [48:0]               prod_pct;
	logic [46:0]               prod_hls;

	always_comb begin
		prod_pct = 49'(num_q[23:0]) * 49'(sxd_pkg::RCP_PCT);
		prod_hls = 47'(num_q[sxd_pkg::DIV_W-1:6]) * 47'(sxd_pkg::RCP_HLS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			hls_q <= divisor == sxd_pkg::DEN_HLS;
		end else if (busy_q) begin
			quo_q <= hls_q ? prod_hls[44:37] : prod_pct[38:31];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/sxd_color_calc.sv
module sxd_color_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  sxd_pkg::calc_req_t req,
	output sxd_pkg::calc_rsp_t rsp
);

	sxd_pkg::calc_state_t st_q, st_d;

	logic [1:0]  ch_q;
	logic        rgb_q, grey_q;
	logic [15:0] par_q [3];
	logic [8:0]  h_q;
	logic [6:0]  l_q, s_q;
	logic [14:0] qv_q, pv_q;
	logic [20:0] v_q;
	logic [7:0]  byte_q [3];

	logic        div_start, div_done;
	logic [7:0]  div_quo;
	logic [sxd_pkg::DIV_W-1:0] div_num;
	logic [sxd_pkg::DEN_W-1:0] div_den;

	logic [8:0]  h_c;
	logic [6:0]  l_c, s_c;
	logic        is_rgb, is_hls;
	logic [14:0] q_c, p_c;
	logic [9:0]  t_c;
	logic [20:0] v_c;
	logic [23:0] par_x255;
	logic [15:0] par_sel;

	sxd_chan_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		is_rgb = req.pu == sxd_pkg::PU_RGB;
		is_hls = req.pu == sxd_pkg::PU_HLS;
		h_c = (req.px > 16'd360) ? 9'd360 : req.px[8:0];
		l_c = (req.py > 16'd100) ? 7'd100 : req.py[6:0];
		s_c = (req.pz > 16'd100) ? 7'd100 : req.pz[6:0];
	end

	always_comb begin
		if (l_q < 7'd50) begin
			q_c = 15'({8'd0, l_q} * (15'd100 + 15'(s_q)));
		end else begin
			q_c = 15'(15'd100 * (15'(l_q) + 15'(s_q)) - {8'd0, l_q} * {8'd0, s_q});
		end
		p_c = 15'(15'd200 * 15'(l_q) - q_c);
	end

	always_comb begin
		case (ch_q)
			2'd0: t_c = (h_q > 9'd240) ? 10'(h_q) - 10'd240 : 10'(h_q) + 10'd120;
			2'd1: t_c = 10'(h_q);
			default: t_c = (h_q < 9'd120) ? 10'(h_q) + 10'd240 : 10'(h_q) - 10'd120;
		endcase
		if (t_c < 10'd60) begin
			v_c = 21'(pv_q) * 21'd60 + 21'(qv_q - pv_q) * 21'(t_c);
		end else if (t_c < 10'd180) begin
			v_c = 21'(qv_q) * 21'd60;
		end else if (t_c < 10'd240) begin
			v_c = 21'(pv_q) * 21'd60 + 21'(qv_q - pv_q) * 21'(10'd240 - t_c);
		end else begin
			v_c = 21'(pv_q) * 21'd60;
		end
	end

	always_comb begin
		par_sel  = grey_q ? 16'(l_q) : par_q[ch_q];
		par_x255 = {par_sel, 8'd0} - 24'(par_sel);
		if (rgb_q || grey_q) begin
			div_num = sxd_pkg::DIV_W'(par_x255);
			div_den = sxd_pkg::DEN_PCT;
		end else begin
			div_num = sxd_pkg::DIV_W'({v_q, 8'd0} - 29'(v_q)) + sxd_pkg::HLS_RND;
			div_den = sxd_pkg::DEN_HLS;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			sxd_pkg::C_IDLE: begin
				if (req.start) begin
					if (is_rgb || (is_hls && s_c == 7'd0)) st_d = sxd_pkg::C_DIVIN;
					else if (is_hls) st_d = sxd_pkg::C_PQ;
					else st_d = sxd_pkg::C_DONE;
				end
			end
			sxd_pkg::C_PQ:    st_d = sxd_pkg::C_HUE;
			sxd_pkg::C_HUE:   st_d = sxd_pkg::C_DIVIN;
			sxd_pkg::C_DIVIN: st_d = sxd_pkg::C_DIV;
			sxd_pkg::C_DIV: begin
				if (div_done) begin
					if (ch_q == 2'd2) st_d = sxd_pkg::C_DONE;
					else if (rgb_q || grey_q) st_d = sxd_pkg::C_DIVIN;
					else st_d = sxd_pkg::C_HUE;
				end
			end
			sxd_pkg::C_DONE:  st_d = sxd_pkg::C_IDLE;
			default:          st_d = sxd_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		div_start = st_q == sxd_pkg::C_DIVIN;
		rsp.done  = st_q == sxd_pkg::C_DONE;
		rsp.color = {byte_q[0], byte_q[1], byte_q[2], 8'hFF};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sxd_pkg::C_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			sxd_pkg::C_IDLE: begin
				ch_q     <= 2'd0;
				rgb_q    <= is_rgb;
				grey_q   <= is_hls && s_c == 7'd0;
				par_q[0] <= req.px;
				par_q[1] <= req.py;
				par_q[2] <= req.pz;
				h_q      <= h_c;
				l_q      <= l_c;
				s_q      <= s_c;
				byte_q[0] <= 8'hFF;
				byte_q[1] <= 8'hFF;
				byte_q[2] <= 8'hFF;
			end
			sxd_pkg::C_PQ: begin
				qv_q <= q_c;
				pv_q <= p_c;
			end
			sxd_pkg::C_HUE: v_q <= v_c;
			sxd_pkg::C_DIV: begin
				if (div_done) begin
					byte_q[ch_q] <= div_quo;
					ch_q <= ch_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/sxd_checker.sv
module sxd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic [7:0]  byte_in,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [11:0] col_x,
	input logic [11:0] band_y,
	input logic [5:0]  pixel_mask,
	input logic [12:0] run_length,
	input logic [31:0] pixel_color,
	input logic [12:0] image_width,
	input logic [12:0] image_height
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({kind, col_x, band_y,
		pixel_mask, run_length, pixel_color, image_width, image_height}))
		else $error("result dropped or changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable({req_type, byte_in}))
		else $error("input item dropped or changed while stalled");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sxd_pkg::KIND_RUN |-> pixel_mask != 6'd0 && run_length != 13'd0)
		else $error("empty column run");

	a_size_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sxd_pkg::KIND_SIZE |->
		(image_width == 13'd0) == (image_height == 13'd0))
		else $error("size with one zero extent");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == sxd_pkg::REQ_END |=> !in_ready ##1 !in_ready)
		else $error("input taken right after end of image");

endmodule

bind sixel_stream_decoder_top sxd_checker u_sxd_checker (.*);
